@@ rtl/gptach_pkg.sv @@
// Shared types, register codes and constants of the gated pulse tachometer.
package gptach_pkg;

   localparam int COUNT_WIDTH_DEF = 20;
   localparam int TICK_W          = 16;
   localparam int RPM_W           = 16;
   localparam int ENG_W           = 14;
   localparam int TRAVEL_W        = 20;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 16;
   localparam int QUEUE_DEPTH     = 2;
   localparam int NUM_CH          = 4;

   localparam logic [15:0] MS_PER_MIN = 16'd60000;
   localparam logic [RPM_W-1:0] RPM_MAX = '1;
   localparam logic [TRAVEL_W-1:0] TRAVEL_MAX = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_N2_PPR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_N3_PPR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFF     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RPM  = 3'd6;

   // channel codes
   localparam logic [1:0] CH_N2     = 2'd0;
   localparam logic [1:0] CH_N3     = 2'd1;
   localparam logic [1:0] CH_WHEEL  = 2'd2;
   localparam logic [1:0] CH_ENGINE = 2'd3;

   // command codes
   localparam logic CMD_PULSE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [1:0] channel;
      logic       low_gear;
   } req_type;

   typedef struct packed {
      logic [RPM_W-1:0]    n2_rpm;
      logic [RPM_W-1:0]    n3_rpm;
      logic [RPM_W-1:0]    wheel_rpm;
      logic [ENG_W-1:0]    engine_rpm;
      logic [TRAVEL_W-1:0] travel_revs;
   } rsp_type;

   typedef struct packed {
      logic [15:0] window_ticks;
      logic [7:0]  n2_pulses_per_rev;
      logic [7:0]  n3_pulses_per_rev;
      logic [9:0]  diff_teeth;
      logic [9:0]  trigger_teeth;
      logic [3:0]  transfer_ratio;
      logic [13:0] max_rpm;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      window_ticks:      16'd1000,
      n2_pulses_per_rev: 8'd60,
      n3_pulses_per_rev: 8'd60,
      diff_teeth:        10'd1,
      trigger_teeth:     10'd1,
      transfer_ratio:    4'd0,
      max_rpm:           14'd7000
   };

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOAD,
      BK_DIV1,
      BK_MUL,
      BK_DIV2,
      BK_STORE,
      BK_OUT
   } back_state_type;

endpackage

@@ rtl/gated_pulse_tachometer_unit.sv @@
// Top level of the four-channel gated pulse tachometer.
//
// Usage:
//   Input words (req_data) carry either a pulse edge on one channel or a
//   millisecond tick. A word is taken when req_push is high and req_full low.
//   Pulse words and ticks are counted at one word per cycle while req_full
//   is low. The tick that closes a gate window hands a snapshot of the
//   counters to a job queue of two entries; req_full is high only while
//   that queue is full. Each window job is worked off by one shared
//   bit-serial divider, one quotient bit per cycle: per channel a
//   pulses-per-rev division and a window division of COUNT_WIDTH+16 steps
//   each. A new window can close while the last one is still being worked
//   off; it waits in the queue until the divider takes it up.
//   The result waits in an output register: it is on rsp_data while
//   rsp_empty is low and leaves on a cycle with rsp_pop high. While the
//   receiver stalls, counting goes on and up to two closed windows queue up.
//   Registers are written through csr_valid/csr_index/csr_wdata; csr_ready
//   is always high. Synchronous reset clears counters, queue and result, and
//   loads the register defaults.
module gated_pulse_tachometer_unit
   import gptach_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  req_type               req_data,
   output logic                  req_full,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int JOB_W = NUM_CH * COUNT_WIDTH + TICK_W + 1;

   cfg_type cfg_ff, cfg_in;

   logic                               job_push, job_full, job_empty, job_pop;
   logic [NUM_CH-1:0][COUNT_WIDTH-1:0] fr_counts, bk_counts;
   logic [TICK_W-1:0]                  fr_elapsed, bk_elapsed;
   logic                               fr_low_gear, bk_low_gear;
   logic [JOB_W-1:0]                   job_wr, job_rd;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WINDOW:  cfg_in.window_ticks      = csr_wdata[15:0];
            CSR_N2_PPR:  cfg_in.n2_pulses_per_rev = csr_wdata[7:0];
            CSR_N3_PPR:  cfg_in.n3_pulses_per_rev = csr_wdata[7:0];
            CSR_DIFF:    cfg_in.diff_teeth        = csr_wdata[9:0];
            CSR_TRIGGER: cfg_in.trigger_teeth     = csr_wdata[9:0];
            CSR_RATIO:   cfg_in.transfer_ratio    = csr_wdata[3:0];
            CSR_MAX_RPM: cfg_in.max_rpm           = csr_wdata[13:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gptach_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_data     (req_data),
      .req_full     (req_full),
      .window_ticks (cfg_ff.window_ticks),
      .job_push     (job_push),
      .job_counts   (fr_counts),
      .job_elapsed  (fr_elapsed),
      .job_low_gear (fr_low_gear),
      .job_full     (job_full)
   );

   assign job_wr = {fr_counts, fr_elapsed, fr_low_gear};

   gptach_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_data (job_wr),
      .full    (job_full),
      .rd_en   (job_pop),
      .rd_data (job_rd),
      .empty   (job_empty)
   );

   assign bk_counts   = job_rd[JOB_W-1 -: NUM_CH*COUNT_WIDTH];
   assign bk_elapsed  = job_rd[TICK_W:1];
   assign bk_low_gear = job_rd[0];

   gptach_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .job_empty    (job_empty),
      .job_counts   (bk_counts),
      .job_elapsed  (bk_elapsed),
      .job_low_gear (bk_low_gear),
      .job_pop      (job_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data)
   );

endmodule

@@ rtl/gptach_queue.sv @@
// Short first-in first-out queue of window jobs between counter front and compute back.
module gptach_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNTW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(DEPTH))
      else $error("queue occupancy beyond depth");
`endif

endmodule

@@ rtl/gptach_front.sv @@
// Front end: takes pulse and tick words, keeps saturating counters, closes gate windows.
module gptach_front
   import gptach_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  req_type                             req_data,
   output logic                                req_full,
   input  logic [15:0]                         window_ticks,
   output logic                                job_push,
   output logic [NUM_CH-1:0][COUNT_WIDTH-1:0]  job_counts,
   output logic [TICK_W-1:0]                   job_elapsed,
   output logic                                job_low_gear,
   input  logic                                job_full
);

   logic [NUM_CH-1:0][COUNT_WIDTH-1:0] count_ff, count_in;
   logic [TICK_W-1:0]                  tick_ff, tick_in;
   logic [TICK_W-1:0]                  tick_next;
   logic                               accept;
   logic                               close;

   assign req_full  = job_full;
   assign accept    = req_push && !job_full;
   // a tick that reaches the window closes it, so tick_ff never reaches all ones and the increment never wraps
   assign tick_next = tick_ff + 1'b1;
   assign close     = accept && (req_data.cmd == CMD_TICK) && (tick_next >= window_ticks);

   assign job_push     = close;
   assign job_counts   = count_ff;
   assign job_elapsed  = tick_next;
   assign job_low_gear = req_data.low_gear;

   always_comb begin
      count_in = count_ff;
      tick_in  = tick_ff;
      if (accept) begin
         if (req_data.cmd == CMD_PULSE) begin
            // hold at all ones
            if (count_ff[req_data.channel] != '1) begin
               count_in[req_data.channel] = count_ff[req_data.channel] + 1'b1;
            end
         end else if (close) begin
            count_in = '0;
            tick_in  = '0;
         end else begin
            tick_in = tick_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         tick_ff  <= '0;
      end else begin
         count_ff <= count_in;
         tick_ff  <= tick_in;
      end
   end

`ifndef SYNTH
   a_tick_no_wrap: assert property (@(posedge clock) disable iff (reset)
      tick_ff != '1)
      else $error("tick count reached all ones");
`endif

endmodule

@@ rtl/gptach_back.sv @@
// Back end: shared bit-serial divider and scaling that turn window counts into speeds.
module gptach_back
   import gptach_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cfg_type                             cfg,
   input  logic                                job_empty,
   input  logic [NUM_CH-1:0][COUNT_WIDTH-1:0]  job_counts,
   input  logic [TICK_W-1:0]                   job_elapsed,
   input  logic                                job_low_gear,
   output logic                                job_pop,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output rsp_type                             rsp_data
);

   localparam int DW     = COUNT_WIDTH + 16;
   localparam int STEP_W = $clog2(DW);

   back_state_type state_ff, state_in;

   logic [1:0]          ch_ff, ch_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [15:0]         rem_ff, rem_in;
   logic [DW-1:0]       quot_ff, quot_in;
   logic [15:0]         divisor_ff, divisor_in;
   logic [RPM_W-1:0]    n2_ff, n2_in, n3_ff, n3_in, wheel_ff, wheel_in;
   logic [ENG_W-1:0]    eng_ff, eng_in;
   logic [TRAVEL_W-1:0] travel_ff, travel_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic do_start, do_load, do_step, do_mul, do_store, do_out;
   logic out_free;

   logic [16:0]   shifted;
   logic          fits;
   logic [16:0]   diff;
   logic [15:0]   rem_next;
   logic [15:0]   ppr_raw;
   logic [15:0]   ppr_sel;
   logic [DW-1:0] product;
   logic [DW+3:0] scaled;
   logic [RPM_W-1:0] rpm_sat;

   assign out_free = !rsp_valid_ff || rsp_pop;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (!job_empty) state_in = BK_LOAD;
         BK_LOAD:  state_in = BK_DIV1;
         BK_DIV1:  if (step_ff == '0) state_in = BK_MUL;
         BK_MUL:   state_in = BK_DIV2;
         BK_DIV2:  if (step_ff == '0) state_in = BK_STORE;
         BK_STORE: state_in = (ch_ff == CH_ENGINE) ? BK_OUT : BK_LOAD;
         BK_OUT:   if (out_free) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      do_start = 1'b0;
      do_load  = 1'b0;
      do_step  = 1'b0;
      do_mul   = 1'b0;
      do_store = 1'b0;
      do_out   = 1'b0;
      job_pop  = 1'b0;
      unique case (state_ff)
         BK_IDLE:  do_start = !job_empty;
         BK_LOAD:  do_load = 1'b1;
         BK_DIV1:  do_step = 1'b1;
         BK_MUL:   do_mul = 1'b1;
         BK_DIV2:  do_step = 1'b1;
         BK_STORE: begin
            do_store = 1'b1;
            job_pop  = (ch_ff == CH_ENGINE);
         end
         BK_OUT:   do_out = out_free;
         default:  do_start = 1'b0;
      endcase
   end

   // one restoring step: remainder stays below the divisor
   assign shifted  = {rem_ff, quot_ff[DW-1]};
   assign fits     = shifted >= {1'b0, divisor_ff};
   assign diff     = shifted - {1'b0, divisor_ff};
   assign rem_next = fits ? diff[15:0] : shifted[15:0];

   always_comb begin
      case (ch_ff)
         CH_N2:    ppr_raw = 16'(cfg.n2_pulses_per_rev);
         CH_N3:    ppr_raw = 16'(cfg.n3_pulses_per_rev);
         CH_WHEEL: ppr_raw = 16'(cfg.diff_teeth);
         default:  ppr_raw = 16'(cfg.trigger_teeth);
      endcase
      // zero pulses per rev divides by one
      ppr_sel = (ppr_raw == '0) ? 16'd1 : ppr_raw;
   end

   assign product = DW'(quot_ff[COUNT_WIDTH-1:0]) * DW'(MS_PER_MIN);

   always_comb begin
      if (job_low_gear && (cfg.transfer_ratio != '0)) begin
         scaled = (DW+4)'(quot_ff) * (DW+4)'(cfg.transfer_ratio);
      end else begin
         scaled = (DW+4)'(quot_ff);
      end
      rpm_sat = (scaled > (DW+4)'(RPM_MAX)) ? RPM_MAX : scaled[RPM_W-1:0];
   end

   always_comb begin
      ch_in        = ch_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      divisor_in   = divisor_ff;
      n2_in        = n2_ff;
      n3_in        = n3_ff;
      wheel_in     = wheel_ff;
      eng_in       = eng_ff;
      travel_in    = travel_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (do_start) begin
         ch_in = CH_N2;
      end
      if (do_load) begin
         quot_in    = DW'(job_counts[ch_ff]);
         rem_in     = '0;
         divisor_in = ppr_sel;
         step_in    = STEP_W'(DW - 1);
      end
      if (do_step) begin
         rem_in  = rem_next;
         quot_in = {quot_ff[DW-2:0], fits};
         step_in = step_ff - 1'b1;
      end
      if (do_mul) begin
         quot_in    = product;
         rem_in     = '0;
         divisor_in = job_elapsed;
         step_in    = STEP_W'(DW - 1);
         if (ch_ff == CH_WHEEL) begin
            travel_in = (quot_ff > DW'(TRAVEL_MAX)) ? TRAVEL_MAX : quot_ff[TRAVEL_W-1:0];
         end
      end
      if (do_store) begin
         case (ch_ff)
            CH_N2:    n2_in = (quot_ff > DW'(RPM_MAX)) ? RPM_MAX : quot_ff[RPM_W-1:0];
            CH_N3:    n3_in = (quot_ff > DW'(RPM_MAX)) ? RPM_MAX : quot_ff[RPM_W-1:0];
            CH_WHEEL: wheel_in = rpm_sat;
            default:  eng_in = (quot_ff > DW'(cfg.max_rpm)) ? cfg.max_rpm
                                                            : quot_ff[ENG_W-1:0];
         endcase
         if (ch_ff != CH_ENGINE) begin
            ch_in = ch_ff + 1'b1;
         end
      end

      if (do_out) begin
         rsp_in.n2_rpm      = n2_ff;
         rsp_in.n3_rpm      = n3_ff;
         rsp_in.wheel_rpm   = wheel_ff;
         rsp_in.engine_rpm  = eng_ff;
         rsp_in.travel_revs = travel_ff;
         rsp_valid_in       = 1'b1;
      end else if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff      <= ch_in;
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
      n2_ff      <= n2_in;
      n3_ff      <= n3_in;
      wheel_ff   <= wheel_in;
      eng_ff     <= eng_in;
      travel_ff  <= travel_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == BK_DIV1 || state_ff == BK_DIV2) && step_ff == '0)
      |=> (state_ff == BK_MUL || state_ff == BK_STORE))
      else $error("divider did not finish on its last step");
   a_out_last_ch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_OUT) |-> (ch_ff == CH_ENGINE))
      else $error("result offered before all channels were computed");
   a_pop_has_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !job_empty)
      else $error("job released from an empty queue");
`endif

endmodule

@@ bench/tach_checker.sv @@
// Checker for the gated pulse tachometer: predicts each window word and compares it.
`timescale 1ns / 100ps
module tach_checker
   import gptach_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  req_type               req_data,
   input  logic                  req_full,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    readings_due
);

   localparam longint unsigned COUNT_TOP = (64'd1 << COUNT_WIDTH_DEF) - 1;

   cfg_type           regs;
   longint unsigned   pulses [NUM_CH];
   logic [TICK_W-1:0] ticks;
   rsp_type           readings_q [$];

   initial begin
      fail_count   = 0;
      readings_due = 0;
   end

   function automatic longint unsigned whole_revs(input longint unsigned n,
                                                  input int unsigned per_rev);
      return n / (per_rev == 0 ? 1 : per_rev);
   endfunction

   function automatic longint unsigned rev_rate(input longint unsigned revs,
                                                input int unsigned elapsed);
      return revs * MS_PER_MIN / elapsed;
   endfunction

   function automatic longint unsigned clip(input longint unsigned v,
                                            input longint unsigned top);
      return v > top ? top : v;
   endfunction

   task automatic count_word(input req_type w);
      int unsigned     elapsed;
      longint unsigned travel;
      longint unsigned wheel;
      rsp_type         r;
      if (w.cmd == CMD_PULSE) begin
         if (pulses[w.channel] < COUNT_TOP) pulses[w.channel]++;
         return;
      end
      ticks = ticks + 1'b1;
      if (ticks == '0) ticks = '1;
      if (ticks < regs.window_ticks) return;
      // divide by the ticks actually elapsed, not by the register
      elapsed = 32'(ticks);
      travel  = whole_revs(pulses[CH_WHEEL], regs.diff_teeth);
      wheel   = rev_rate(travel, elapsed);
      if (w.low_gear && regs.transfer_ratio != 0) wheel = wheel * regs.transfer_ratio;
      r.n2_rpm = RPM_W'(clip(rev_rate(whole_revs(pulses[CH_N2], regs.n2_pulses_per_rev),
                                      elapsed), RPM_MAX));
      r.n3_rpm = RPM_W'(clip(rev_rate(whole_revs(pulses[CH_N3], regs.n3_pulses_per_rev),
                                      elapsed), RPM_MAX));
      r.wheel_rpm = RPM_W'(clip(wheel, RPM_MAX));
      r.engine_rpm = ENG_W'(clip(rev_rate(whole_revs(pulses[CH_ENGINE], regs.trigger_teeth),
                                          elapsed), regs.max_rpm));
      r.travel_revs = TRAVEL_W'(clip(travel, TRAVEL_MAX));
      readings_q.push_back(r);
      foreach (pulses[i]) pulses[i] = 0;
      ticks = '0;
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         regs = CFG_RESET;
         foreach (pulses[i]) pulses[i] = 0;
         ticks = '0;
         readings_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            // keep only the bits each register holds
            case (csr_index)
               CSR_WINDOW:  regs.window_ticks      = csr_wdata;
               CSR_N2_PPR:  regs.n2_pulses_per_rev = csr_wdata[7:0];
               CSR_N3_PPR:  regs.n3_pulses_per_rev = csr_wdata[7:0];
               CSR_DIFF:    regs.diff_teeth        = csr_wdata[9:0];
               CSR_TRIGGER: regs.trigger_teeth     = csr_wdata[9:0];
               CSR_RATIO:   regs.transfer_ratio    = csr_wdata[3:0];
               CSR_MAX_RPM: regs.max_rpm           = csr_wdata[13:0];
               default: ;
            endcase
         end
         if (!rsp_empty && rsp_pop) begin
            if (readings_q.size() == 0) begin
               $error("result word with no closed window pending: %p", rsp_data);
               fail_count++;
            end else begin
               want = readings_q.pop_front();
               check_field("n2_rpm", want.n2_rpm, rsp_data.n2_rpm);
               check_field("n3_rpm", want.n3_rpm, rsp_data.n3_rpm);
               check_field("wheel_rpm", want.wheel_rpm, rsp_data.wheel_rpm);
               check_field("engine_rpm", want.engine_rpm, rsp_data.engine_rpm);
               check_field("travel_revs", want.travel_revs, rsp_data.travel_revs);
            end
         end
         if (req_push && !req_full) count_word(req_data);
      end
      readings_due = readings_q.size();
   end

endmodule

@@ bench/tb.sv @@
// Testbench top: drives words and register writes into the tachometer and reports the verdict.
`timescale 1ns / 100ps
module tb
   import gptach_pkg::*;
();

   localparam int SETTLE_CYCLES   = 400;
   localparam int RANDOM_PHASES   = 10;
   localparam int WORDS_PER_PHASE = 125;

   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG = '1;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   req_type               req_data;
   logic                  req_full;
   logic                  rsp_empty;
   logic                  rsp_pop;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    readings_due;
   int                    send_idle_pct  = 0;
   int                    recv_stall_pct = 0;

   gated_pulse_tachometer_unit dut (
      .clock, .reset,
      .req_push, .req_data, .req_full,
      .rsp_empty, .rsp_pop, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   tach_checker tach_check (
      .clock, .reset,
      .req_push, .req_data, .req_full,
      .rsp_empty, .rsp_pop, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .fail_count, .readings_due
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         rsp_pop = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      #40_000_000;
      $display("FAIL gated_pulse_tachometer_unit");
      $finish;
   end

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 71; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 71; end
         default:       begin send_idle_pct = 8;  recv_stall_pct = 8;  end
      endcase
   endtask

   // push stays high from one word to the next unless an idle gap comes between
   task automatic send_word(input req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push = 1'b0;
         req_data = 4'($urandom_range(15));
         @(negedge clock);
      end
      req_push = 1'b1;
      req_data = w;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic pulse_burst(input logic [1:0] ch, input int n);
      req_type w;
      repeat (n) begin
         w.cmd      = CMD_PULSE;
         w.channel  = ch;
         w.low_gear = 1'($urandom_range(1));
         send_word(w);
      end
   endtask

   task automatic tick(input logic low_gear);
      req_type w;
      w.cmd      = CMD_TICK;
      w.channel  = 2'($urandom_range(3));
      w.low_gear = low_gear;
      send_word(w);
   endtask

   function automatic req_type random_word();
      req_type w;
      w     = 4'($urandom_range(15));
      w.cmd = ($urandom_range(3) == 0) ? CMD_TICK : CMD_PULSE;
      return w;
   endfunction

   // fill the bits above the register width with junk
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned val,
                            input int width);
      logic [CSR_DATA_W-1:0] junk;
      junk      = CSR_DATA_W'($urandom) << width;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(val) | junk;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // drain all results, then let the counting path go quiet
   task automatic settle();
      req_push = 1'b0;
      while (readings_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic int unsigned skewed(input int unsigned lo_top, input int unsigned top);
      case ($urandom_range(9))
         0:       return 0;
         1:       return top;
         2:       return $urandom_range(top);
         default: return $urandom_range(lo_top, 1);
      endcase
   endfunction

   task automatic random_config();
      int unsigned win;
      case ($urandom_range(9))
         0:       win = 0;
         1:       win = $urandom_range(40, 7);
         default: win = $urandom_range(6, 1);
      endcase
      write_reg(CSR_WINDOW, win, 16);
      write_reg(CSR_N2_PPR, skewed(4, 255), 8);
      write_reg(CSR_N3_PPR, skewed(4, 255), 8);
      write_reg(CSR_DIFF, skewed(3, 1023), 10);
      write_reg(CSR_TRIGGER, skewed(3, 1023), 10);
      write_reg(CSR_RATIO, $urandom_range(15), 4);
      write_reg(CSR_MAX_RPM, ($urandom_range(3) == 0) ? 16383 : $urandom_range(16383), 14);
      if ($urandom_range(1)) write_reg(CSR_NO_REG, $urandom_range(65535), 0);
   endtask

   initial begin
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero divisor, wide divisors, ratio at top, engine clamped to zero
      set_idling(IDLE_NONE);
      write_reg(CSR_WINDOW, 2, 16);
      write_reg(CSR_N2_PPR, 0, 8);
      write_reg(CSR_N3_PPR, 255, 8);
      write_reg(CSR_DIFF, 1023, 10);
      write_reg(CSR_TRIGGER, 1, 10);
      write_reg(CSR_RATIO, 15, 4);
      write_reg(CSR_MAX_RPM, 0, 14);
      write_reg(CSR_NO_REG, 16'h1234, 0);
      pulse_burst(CH_N2, 3);
      pulse_burst(CH_N3, 2);
      pulse_burst(CH_WHEEL, 3);
      pulse_burst(CH_ENGINE, 2);
      tick(1'b1);
      tick(1'b0);
      settle();

      // window of zero: every tick closes; saturate wheel and clamp engine at the top
      write_reg(CSR_WINDOW, 0, 16);
      write_reg(CSR_N2_PPR, 1, 8);
      write_reg(CSR_N3_PPR, 1, 8);
      write_reg(CSR_DIFF, 1, 10);
      write_reg(CSR_MAX_RPM, 16383, 14);
      pulse_burst(CH_N2, 1);
      pulse_burst(CH_WHEEL, 2);
      pulse_burst(CH_ENGINE, 1);
      tick(1'b1);
      tick(1'b0);
      settle();

      // longest window, then lower it while ticks are already counted
      write_reg(CSR_WINDOW, 65535, 16);
      write_reg(CSR_RATIO, 0, 4);
      pulse_burst(CH_N3, 2);
      tick(1'b0);
      tick(1'b1);
      tick(1'b0);
      settle();
      write_reg(CSR_WINDOW, 1, 16);
      tick(1'b1);
      settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_idling(idle_mode_type'(p % 4));
         random_config();
         repeat (WORDS_PER_PHASE) send_word(random_word());
         settle();
      end

      if (fail_count == 0) begin
         $display("PASS gated_pulse_tachometer_unit");
      end else begin
         $display("FAIL gated_pulse_tachometer_unit");
      end
      $finish;
   end

endmodule
